// File: src/nrc_pkg.sv
// shared constants and types for the nearest-neighbor rate converter fifo
package nrc_pkg;

  // fifo storage
  localparam int DEPTH       = 1024;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int SAMPLE_BITS = 32;

  // push limit per source sample
  localparam int MAX_PUSHES = 8;
  localparam int CNT_W      = $clog2(MAX_PUSHES + 1);

  // fixed port widths
  localparam int OP_W    = 2;
  localparam int STEP_W  = 24;
  localparam int PHASE_W = 25;
  localparam int FILL_W  = 10;
  localparam int PUSH_W  = 4;

  // q16 constants
  localparam logic [PHASE_W-1:0] ONE_Q16    = PHASE_W'(65536);
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(65536);

  // item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // controls from the sequencer to the phase unit
  typedef struct packed {
    logic start;      // new item accepted, zero the push count
    logic step;       // one phase step and one push slot
    logic wrap;       // end of item, fold phase back by one
    logic batch_end;  // item closes its batch, phase restarts
  } phase_ctrl_t;

endpackage

// File: src/nearest_rate_converter_fifo_core.sv
// top level: rate converter sequencer, fifo pointers, sample ram and result register
// item flow: a write item does n phase steps in S_WRITE (n = pushes wanted, 0..8), a wrap,
//   then S_DONE; a read item S_READ, S_RDWAIT, S_DONE (S_READ, S_DONE on an empty fifo);
//   a clear item S_CLEAR, S_DONE; a no-op item S_DONE; one item at a time, the next taken
//   while a result waits at the output; one phase step per cycle, a ram write per step
//   unless full or stopped; reset (rst, synchronous): state reset, S_INIT clears slot 0
module nearest_rate_converter_fifo_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [nrc_pkg::OP_W-1:0]         op,
  input  logic [nrc_pkg::SAMPLE_BITS-1:0]  sample,
  input  logic                             batch_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [nrc_pkg::SAMPLE_BITS-1:0]  read_sample,
  output logic                             read_valid,
  output logic [nrc_pkg::PUSH_W-1:0]       pushed_count,
  output logic                             dropped,
  output logic [nrc_pkg::FILL_W-1:0]       fill_level,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nrc_pkg::STEP_W-1:0]       step_ratio
);

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_WRITE  = 7'b0000100,
    S_READ   = 7'b0001000,
    S_RDWAIT = 7'b0010000,
    S_CLEAR  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;

  logic [nrc_pkg::STEP_W-1:0]      step_reg;
  logic [nrc_pkg::PTR_W-1:0]       rp;
  logic [nrc_pkg::PTR_W-1:0]       wp;
  logic                            stopped;
  logic [nrc_pkg::SAMPLE_BITS-1:0] sample_r;
  logic                            last_r;
  logic [nrc_pkg::SAMPLE_BITS-1:0] res_sample;
  logic                            res_valid;
  logic [nrc_pkg::CNT_W-1:0]       res_pushed;
  logic                            res_dropped;

  logic [nrc_pkg::PTR_W-1:0]       fill;
  logic                            full;
  logic                            accept;
  logic                            more;
  logic                            result_load;
  nrc_pkg::phase_ctrl_t            pctrl;

  logic                            ram_we;
  logic [nrc_pkg::PTR_W-1:0]       ram_waddr;
  logic [nrc_pkg::SAMPLE_BITS-1:0] ram_wdata;
  logic                            ram_re;
  logic [nrc_pkg::SAMPLE_BITS-1:0] ram_rdata;

  // handshakes
  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign cfg_ready   = 1'b1;
  assign result_load = (state == S_DONE) && (!out_valid || out_ready);

  // fifo occupancy, one slot kept between read and write pointers
  assign fill = wp - rp - 1'b1;
  assign full = (fill >= nrc_pkg::PTR_W'(nrc_pkg::DEPTH - 2));

  // phase unit controls
  always_comb begin
    pctrl.start     = accept;
    pctrl.step      = (state == S_WRITE) && more;
    pctrl.wrap      = (state == S_WRITE) && !more;
    pctrl.batch_end = last_r;
  end

  // ram port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wp;
    ram_wdata = sample_r;
    if (state == S_INIT || state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = '0;
    end else if (state == S_WRITE) begin
      ram_we = more && !stopped && !full;
    end
  end
  assign ram_re = (state == S_READ) && (fill != '0);

  nrc_ram #(
    .WIDTH (nrc_pkg::SAMPLE_BITS),
    .DEPTH (nrc_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  nrc_phase u_phase (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (pctrl),
    .step_ratio (step_reg),
    .more       (more)
  );

  // step ratio register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_reg <= nrc_pkg::STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      step_reg <= step_ratio;
    end
  end

  // sequencer, pointers and batch stop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      rp      <= '0;
      wp      <= nrc_pkg::PTR_W'(1);
      stopped <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            unique case (nrc_pkg::op_t'(op))
              nrc_pkg::OP_WRITE: state <= S_WRITE;
              nrc_pkg::OP_READ:  state <= S_READ;
              nrc_pkg::OP_CLEAR: state <= S_CLEAR;
              nrc_pkg::OP_NOP:   state <= S_DONE;
              default:           state <= S_DONE;
            endcase
          end
        end
        S_WRITE: begin
          if (more) begin
            if (!stopped && full) begin
              stopped <= 1'b1;
            end else if (!stopped) begin
              wp <= wp + 1'b1;
            end
          end else begin
            if (last_r) begin
              stopped <= 1'b0;
            end
            state <= S_DONE;
          end
        end
        S_READ: begin
          if (fill != '0) begin
            rp    <= rp + 1'b1;
            state <= S_RDWAIT;
          end else begin
            state <= S_DONE;
          end
        end
        S_RDWAIT: begin
          state <= S_DONE;
        end
        S_CLEAR: begin
          rp    <= '0;
          wp    <= nrc_pkg::PTR_W'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (result_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  // item payload and result accumulation
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r    <= sample;
      last_r      <= batch_last;
      res_sample  <= '0;
      res_valid   <= 1'b0;
      res_pushed  <= '0;
      res_dropped <= 1'b0;
    end else if (state == S_WRITE && more) begin
      if (stopped || full) begin
        res_dropped <= 1'b1;
      end else begin
        res_pushed <= res_pushed + 1'b1;
      end
    end else if (state == S_RDWAIT) begin
      res_sample <= ram_rdata;
      res_valid  <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      read_sample  <= res_sample;
      read_valid   <= res_valid;
      pushed_count <= nrc_pkg::PUSH_W'(res_pushed);
      dropped      <= res_dropped;
      fill_level   <= nrc_pkg::FILL_W'(fill);
    end
  end

  // occupancy never reaches the reserved slot
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill <= nrc_pkg::PTR_W'(nrc_pkg::DEPTH - 2))
    else $error("fifo occupancy beyond capacity");

  // a push never lands in a full fifo
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == S_WRITE) |-> !full && !stopped)
    else $error("push into full fifo");

  // a result is never both a pop and a push
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(read_valid && pushed_count != '0))
    else $error("result reports pop and push together");

  // one item in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second item accepted while busy");

endmodule

// File: src/nrc_ram.sv
// generic single-write, single-read ram with registered read data
module nrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/nrc_phase.sv
// phase accumulator and push counter for one source sample
module nrc_phase (
  input  logic                        clk,
  input  logic                        rst,
  input  nrc_pkg::phase_ctrl_t        ctrl,
  input  logic [nrc_pkg::STEP_W-1:0]  step_ratio,
  output logic                        more
);

  logic [nrc_pkg::PHASE_W-1:0] phase;
  logic [nrc_pkg::CNT_W-1:0]   cnt;

  // another output index falls inside this source sample, within the push limit
  assign more = (phase < nrc_pkg::ONE_Q16) &&
                (cnt < nrc_pkg::CNT_W'(nrc_pkg::MAX_PUSHES));

  // phase and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      cnt   <= '0;
    end else begin
      if (ctrl.start) begin
        cnt <= '0;
      end else if (ctrl.step) begin
        cnt   <= cnt + 1'b1;
        phase <= phase + nrc_pkg::PHASE_W'(step_ratio);
      end else if (ctrl.wrap) begin
        // push limit or batch end restarts the phase at zero
        if (ctrl.batch_end || phase < nrc_pkg::ONE_Q16) begin
          phase <= '0;
        end else begin
          phase <= phase - nrc_pkg::ONE_Q16;
        end
      end
    end
  end

  // count stays within the push limit
  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    cnt <= nrc_pkg::CNT_W'(nrc_pkg::MAX_PUSHES))
    else $error("push count beyond limit");

  // a step is only taken while another push is due
  a_step_due: assert property (@(posedge clk) disable iff (rst)
    ctrl.step |-> more)
    else $error("phase step without a due push");

  // after a wrap the phase is below 1 << 24, that is below 256 samples
  a_wrap_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.wrap && !ctrl.start && !ctrl.step |=> phase < nrc_pkg::PHASE_W'(1 << 24))
    else $error("phase out of range after wrap");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// testbench for the nearest-neighbor rate converter fifo core with a scoreboard predictor
module tb_top;
  import nrc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 900;
  localparam int LONG_HOLD    = 400;

  typedef struct {
    op_t                    op;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   batch_last;
  } conv_item_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] read_sample;
    logic                   read_valid;
    logic [PUSH_W-1:0]      pushed_count;
    logic                   dropped;
    logic [FILL_W-1:0]      fill_level;
  } conv_result_t;

  // stimulus flavors for the random segments
  typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_mode_t;

  // clock, reset and block ports
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [OP_W-1:0]        op = OP_NOP;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic                   batch_last = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] read_sample;
  logic                   read_valid;
  logic [PUSH_W-1:0]      pushed_count;
  logic                   dropped;
  logic [FILL_W-1:0]      fill_level;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [STEP_W-1:0]      step_ratio = STEP_RESET;

  // predictor state
  logic [SAMPLE_BITS-1:0] ring_mem [DEPTH];
  logic [PTR_W-1:0]       rd_ptr;
  logic [PTR_W-1:0]       wr_ptr;
  logic [PHASE_W-1:0]     phase_acc;
  logic                   batch_halted;
  logic [STEP_W-1:0]      step_now;

  // queues, handshake flags and counters
  conv_item_t   stim_items[$];
  conv_result_t predicted_results[$];
  conv_item_t   cur_item = '{OP_NOP, '0, 1'b0};
  bit           in_acc = 1'b0;
  bit           out_acc = 1'b0;
  bit           in_busy = 1'b0;
  int           in_gap = 0;
  int           in_quiet = 0;
  int           out_gap = 0;
  int           out_quiet = 0;
  int           hold_left = 0;
  bit           long_hold_done = 1'b0;
  int           batch_left = 3;
  int           mismatches = 0;
  int           cycle_count = 0;

  nearest_rate_converter_fifo_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .sample       (sample),
    .batch_last   (batch_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_sample  (read_sample),
    .read_valid   (read_valid),
    .pushed_count (pushed_count),
    .dropped      (dropped),
    .fill_level   (fill_level),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .step_ratio   (step_ratio)
  );

  always #1 clk = ~clk;

  // expected result of one item, advancing the predictor state
  function automatic conv_result_t predict_converter(conv_item_t it);
    conv_result_t res;
    int           wanted;
    logic         halt;
    logic [FILL_W-1:0] fill;
    res = '{'0, 1'b0, '0, 1'b0, '0};
    case (it.op)
      OP_WRITE: begin
        // nearest-neighbor phase walk, capped at the push limit
        wanted = 0;
        while (phase_acc < ONE_Q16 && wanted < MAX_PUSHES) begin
          wanted++;
          phase_acc = phase_acc + PHASE_W'(step_now);
        end
        phase_acc = (phase_acc >= ONE_Q16) ? phase_acc - ONE_Q16 : '0;
        // store copies until the ring is full or the batch has stopped
        halt = 1'b0;
        for (int k = 0; k < wanted; k++) begin
          fill = wr_ptr - rd_ptr - 1'b1;
          if (!halt) begin
            if (batch_halted) begin
              res.dropped = 1'b1;
              halt = 1'b1;
            end else if (int'(fill) + 2 >= DEPTH) begin
              batch_halted = 1'b1;
              res.dropped = 1'b1;
              halt = 1'b1;
            end else begin
              ring_mem[wr_ptr] = it.sample;
              wr_ptr = wr_ptr + 1'b1;
              res.pushed_count = res.pushed_count + 1'b1;
            end
          end
        end
        if (it.batch_last) begin
          phase_acc = '0;
          batch_halted = 1'b0;
        end
      end
      OP_READ: begin
        fill = wr_ptr - rd_ptr - 1'b1;
        if (fill != 0) begin
          res.read_sample = ring_mem[rd_ptr];
          res.read_valid = 1'b1;
          rd_ptr = rd_ptr + 1'b1;
        end
      end
      OP_CLEAR: begin
        ring_mem[0] = '0;
        rd_ptr = '0;
        wr_ptr = PTR_W'(1);
      end
      default: begin
      end
    endcase
    res.fill_level = wr_ptr - rd_ptr - 1'b1;
    return res;
  endfunction

  // idle draw per item, with occasional stretches of back-to-back traffic
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) quiet_left = $urandom_range(20, 80);
    return $urandom_range(0, 18);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic add_item(input op_t o, input logic [SAMPLE_BITS-1:0] s, input logic l);
    stim_items.push_back('{o, s, l});
  endtask

  // one random item; writes form batches of random length
  task automatic add_random(input seg_mode_t mode);
    int         r;
    conv_item_t it;
    r = $urandom_range(0, 99);
    it.sample = $urandom;
    it.batch_last = 1'b0;
    case (mode)
      SEG_FILL:  it.op = (r < 85) ? OP_WRITE : (r < 97) ? OP_READ : OP_NOP;
      SEG_DRAIN: it.op = (r < 20) ? OP_WRITE : (r < 97) ? OP_READ : OP_NOP;
      default:   it.op = (r < 50) ? OP_WRITE : (r < 93) ? OP_READ : (r < 97) ? OP_NOP : OP_CLEAR;
    endcase
    if (it.op == OP_WRITE) begin
      batch_left--;
      if (batch_left <= 0) begin
        it.batch_last = 1'b1;
        batch_left = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
      end
    end
    stim_items.push_back(it);
  endtask

  // wait until nothing is queued, offered or expected
  task automatic wait_idle();
    while (stim_items.size() != 0 || in_valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    step_ratio = value;
    do @(posedge clk); while (!cfg_ready);
    step_now = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // handshake sampling and result check
  always @(posedge clk) begin
    conv_result_t want;
    in_acc = !rst && in_valid && in_ready;
    out_acc = !rst && out_valid && out_ready;
    if (out_acc) begin
      if (predicted_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none actual fill 0x%0h", $time, fill_level);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        check_field("read_sample", want.read_sample, read_sample);
        check_field("read_valid", want.read_valid, read_valid);
        check_field("pushed_count", want.pushed_count, pushed_count);
        check_field("dropped", want.dropped, dropped);
        check_field("fill_level", want.fill_level, fill_level);
      end
    end
    if (in_acc) predicted_results.push_back(predict_converter(cur_item));
  end

  // input driver
  always @(negedge clk) begin
    if (in_acc) begin
      in_busy = 1'b0;
      in_gap = draw_gap(in_quiet);
    end
    if (!rst && !in_busy) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (stim_items.size() > 0) begin
        cur_item = stim_items.pop_front();
        in_busy = 1'b1;
      end
    end
    in_valid <= in_busy;
    op <= cur_item.op;
    sample <= cur_item.sample;
    batch_last <= cur_item.batch_last;
  end

  // result receiver, with one long hold-off while items keep coming
  always @(negedge clk) begin
    if (out_acc) begin
      out_gap = draw_gap(out_quiet);
      if (!long_hold_done && stim_items.size() > 30) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("nearest_rate_converter_fifo_core verification failed");
    $finish;
  end

  // stimulus sequence
  initial begin
    int                seg;
    int                n;
    int                random_done;
    seg_mode_t         mode;
    logic [STEP_W-1:0] ratio;

    foreach (ring_mem[i]) ring_mem[i] = '0;
    rd_ptr = '0;
    wr_ptr = PTR_W'(1);
    phase_acc = '0;
    batch_halted = 1'b0;
    step_now = STEP_RESET;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset ratio: empty read, one-sample delay, clear mid batch, no-op
    add_item(OP_READ, 32'h0, 1'b0);
    add_item(OP_NOP, 32'h12345678, 1'b1);
    add_item(OP_WRITE, 32'hFFFFFFFF, 1'b0);
    add_item(OP_WRITE, 32'h00000000, 1'b1);
    add_item(OP_READ, 32'h0, 1'b0);
    add_item(OP_READ, 32'h0, 1'b0);
    add_item(OP_READ, 32'h0, 1'b0);
    add_item(OP_READ, 32'h0, 1'b0);
    add_item(OP_WRITE, 32'h5A5A5A5A, 1'b1);
    add_item(OP_CLEAR, 32'h0, 1'b0);
    add_item(OP_READ, 32'h0, 1'b0);
    add_item(OP_WRITE, 32'h80000001, 1'b0);
    add_item(OP_CLEAR, 32'h0, 1'b0);
    add_item(OP_WRITE, 32'h7FFFFFFE, 1'b1);
    add_item(OP_READ, 32'h0, 1'b0);
    wait_idle();

    // largest ratio: one copy per batch start, later samples skipped
    write_step(24'hFFFFFF);
    add_item(OP_WRITE, 32'h11111111, 1'b0);
    add_item(OP_WRITE, 32'h22222222, 1'b0);
    add_item(OP_WRITE, 32'h33333333, 1'b1);
    add_item(OP_READ, 32'h0, 1'b0);
    add_item(OP_READ, 32'h0, 1'b0);
    wait_idle();

    // ratio of one eighth: eight copies per sample
    write_step(24'd8192);
    add_item(OP_WRITE, 32'hC3C3C3C3, 1'b1);
    add_item(OP_READ, 32'h0, 1'b0);
    wait_idle();

    // zero ratio: push limit stops the loop
    write_step(24'd0);
    add_item(OP_WRITE, 32'h0F0F0F0F, 1'b0);
    add_item(OP_WRITE, 32'hF0F0F0F0, 1'b1);
    add_item(OP_READ, 32'h0, 1'b0);
    wait_idle();

    // random segments, each under its own ratio
    seg = 0;
    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      case (seg % 6)
        0:       ratio = STEP_W'($urandom_range(8192, 24000));
        1:       ratio = STEP_W'($urandom_range(61536, 105536));
        2:       ratio = STEP_W'($urandom_range(24000, 300000));
        3:       ratio = (seg % 12 == 3) ? 24'hFFFFFF : 24'd8192;
        4:       ratio = STEP_W'($urandom_range(0, 8191));
        default: ratio = STEP_W'($urandom_range(300000, 24'hFFFFFF));
      endcase
      write_step(ratio);
      if (seg == 0) begin
        mode = SEG_FILL;
        n = 220;
      end else begin
        mode = seg_mode_t'($urandom_range(0, 2));
        n = $urandom_range(40, 110);
      end
      repeat (n) add_random(mode);
      random_done += n;
      seg++;
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("nearest_rate_converter_fifo_core verification clean");
    end else begin
      $display("nearest_rate_converter_fifo_core verification failed");
    end
    $finish;
  end

endmodule

// File: nearest_rate_converter_fifo_core.f
src/nrc_pkg.sv
src/nrc_ram.sv
src/nrc_phase.sv
src/nearest_rate_converter_fifo_core.sv
tb/tb_top.sv
